>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the frame parser RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define EFP_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
`define EFP_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`else
`define EFP_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define EFP_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

>>> rtl/efp_pkg.sv
// ----------------------------------------------------------------------------
// EMI frame parser package
// Types, widths, character codes and error codes shared by the parser.
// ----------------------------------------------------------------------------
`default_nettype none

package efp_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned FIELD_W = 6;
  localparam int unsigned POS_W   = 17;
  localparam int unsigned NUM_W   = 7;
  localparam int unsigned HEX_W   = 9;
  localparam int unsigned EXTRA_W = 8;
  localparam int unsigned NACK_CNT_W = 2;

  localparam int unsigned OP01_FIELDS_DEF = 4;
  localparam int unsigned OP5X_FIELDS_DEF = 33;
  localparam int unsigned OP60_FIELDS_DEF = 14;

  localparam logic [BYTE_W-1:0] CH_STX   = 8'h02;
  localparam logic [BYTE_W-1:0] CH_ETX   = 8'h03;
  localparam logic [BYTE_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [BYTE_W-1:0] CH_0     = 8'h30;
  localparam logic [BYTE_W-1:0] CH_9     = 8'h39;
  localparam logic [BYTE_W-1:0] CH_UA    = 8'h41;
  localparam logic [BYTE_W-1:0] CH_UF    = 8'h46;
  localparam logic [BYTE_W-1:0] CH_LA    = 8'h61;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h66;
  localparam logic [BYTE_W-1:0] CH_ACK   = 8'h41;
  localparam logic [BYTE_W-1:0] CH_NACK  = 8'h4E;
  localparam logic [BYTE_W-1:0] CH_OP    = 8'h4F;
  localparam logic [BYTE_W-1:0] CH_REPLY = 8'h52;

  localparam logic [NUM_W-1:0] OP_01 = 7'd1;
  localparam logic [NUM_W-1:0] OP_31 = 7'd31;
  localparam logic [NUM_W-1:0] OP_51 = 7'd51;
  localparam logic [NUM_W-1:0] OP_53 = 7'd53;
  localparam logic [NUM_W-1:0] OP_60 = 7'd60;

  localparam logic [HEX_W-1:0] HEX_EMPTY = 9'h1FF;
  localparam logic [HEX_W-1:0] HEX_BAD   = 9'h100;

  typedef enum logic [3:0] {
    ERR_NONE, ERR_MARKER, ERR_DIGIT, ERR_LENGTH, ERR_DIR,
    ERR_TYPE, ERR_ACK, ERR_FIELDS, ERR_CHECKSUM, ERR_NACK
  } err_kind_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;
  } efp_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  field_byte;
    logic [FIELD_W-1:0] field_index;
    logic               field_byte_valid;
    logic               frame_done;
    logic               frame_ok;
    err_kind_t          error_kind;
    logic [NUM_W-1:0]   transaction_number;
    logic [NUM_W-1:0]   operation_type;
    logic               is_reply;
    logic               positive_ack;
    logic [NUM_W-1:0]   nack_code;
    logic [EXTRA_W-1:0] extra_field_count;
  } efp_result_t;

endpackage

`default_nettype wire

>>> rtl/efp_in_stage.sv
// ----------------------------------------------------------------------------
// EMI frame parser input register
// Holds one accepted byte until the parser step consumes it.
// ----------------------------------------------------------------------------
`default_nettype none

module efp_in_stage (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire efp_pkg::efp_item_t in_item,
  input  wire logic              consume,
  output logic                   item_valid,
  output efp_pkg::efp_item_t     item
);

  logic               valid_r;
  efp_pkg::efp_item_t item_r;
  logic               load;

  assign in_stall   = valid_r && !consume;
  assign load       = in_valid && !in_stall;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (consume) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= in_item;
    end
  end

endmodule

`default_nettype wire

>>> rtl/efp_core.sv
// ----------------------------------------------------------------------------
// EMI frame parser step
// Frame state registers and the per-byte decode, check and stream logic.
// ----------------------------------------------------------------------------
`default_nettype none

module efp_core #(
  parameter int unsigned OP01_FIELDS = efp_pkg::OP01_FIELDS_DEF,
  parameter int unsigned OP5X_FIELDS = efp_pkg::OP5X_FIELDS_DEF,
  parameter int unsigned OP60_FIELDS = efp_pkg::OP60_FIELDS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               fire,
  input  wire efp_pkg::efp_item_t item,
  output efp_pkg::efp_result_t    res
);

  localparam int unsigned PW = efp_pkg::POS_W;
  localparam int unsigned NW = efp_pkg::NUM_W;
  localparam int unsigned FW = efp_pkg::FIELD_W;
  localparam int unsigned BW = efp_pkg::BYTE_W;

  logic [PW-1:0]                   pos_r, pos_nxt;
  logic [PW-1:0]                   len_r, len_nxt;
  logic [NW-1:0]                   trn_r, trn_nxt;
  logic [NW-1:0]                   op_r, op_nxt;
  logic                            reply_r, reply_nxt;
  logic                            ack_r, ack_nxt;
  logic [FW-1:0]                   fc_r, fc_nxt;
  logic [FW-1:0]                   fe_r, fe_nxt;
  logic [efp_pkg::EXTRA_W-1:0]     extra_r, extra_nxt;
  logic [BW-1:0]                   sum_r, sum_nxt;
  logic [BW-1:0]                   rb0_r, rb0_nxt;
  logic [BW-1:0]                   rb1_r, rb1_nxt;
  logic [efp_pkg::HEX_W-1:0]       hex_r, hex_nxt;
  logic [NW-1:0]                   nack_r, nack_nxt;
  logic [efp_pkg::NACK_CNT_W-1:0]  ncnt_r, ncnt_nxt;
  efp_pkg::err_kind_t              err_r, err_nxt;

  function automatic logic [PW-1:0] dec_shift(input logic [PW-1:0] acc,
                                              input logic [3:0] d);
    logic [PW+3:0] t;
    t = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + (PW+4)'(d);
    return t[PW-1:0];
  endfunction

  function automatic logic [4:0] hex_val(input logic [BW-1:0] c);
    logic [4:0] h;
    h = 5'h10;
    if (c >= efp_pkg::CH_0 && c <= efp_pkg::CH_9) begin
      h = {1'b0, 4'(c - efp_pkg::CH_0)};
    end else if (c >= efp_pkg::CH_UA && c <= efp_pkg::CH_UF) begin
      h = {1'b0, 4'(c - efp_pkg::CH_UA + 8'd10)};
    end else if (c >= efp_pkg::CH_LA && c <= efp_pkg::CH_LF) begin
      h = {1'b0, 4'(c - efp_pkg::CH_LA + 8'd10)};
    end
    return h;
  endfunction

  function automatic logic type_known(input logic [NW-1:0] op);
    return op == efp_pkg::OP_01 || op == efp_pkg::OP_31 || op == efp_pkg::OP_60 ||
           (op >= efp_pkg::OP_51 && op <= efp_pkg::OP_53);
  endfunction

  function automatic logic [FW-1:0] count_for_op(input logic [NW-1:0] op);
    logic [FW-1:0] n;
    n = '0;
    if (op == efp_pkg::OP_01) begin
      n = FW'(OP01_FIELDS);
    end else if (op == efp_pkg::OP_31) begin
      n = FW'(2);
    end else if (op >= efp_pkg::OP_51 && op <= efp_pkg::OP_53) begin
      n = FW'(OP5X_FIELDS);
    end else if (op == efp_pkg::OP_60) begin
      n = FW'(OP60_FIELDS);
    end
    return n;
  endfunction

  function automatic logic [FW-1:0] count_for_reply(input logic [NW-1:0] op,
                                                    input logic ack);
    logic [FW-1:0] n;
    n = '0;
    if (op == efp_pkg::OP_01 || op == efp_pkg::OP_31 || op == efp_pkg::OP_60) begin
      n = ack ? FW'(2) : FW'(3);
    end else if (op >= efp_pkg::OP_51 && op <= efp_pkg::OP_53) begin
      n = FW'(3);
    end
    return n;
  endfunction

  function automatic efp_pkg::err_kind_t min_err(input efp_pkg::err_kind_t cur,
                                                 input logic [9:1] flags);
    efp_pkg::err_kind_t r;
    r = cur;
    for (int k = 9; k >= 1; k--) begin
      if (flags[k] && (r == efp_pkg::ERR_NONE || 4'(k) < r)) begin
        r = efp_pkg::err_kind_t'(4'(k));
      end
    end
    return r;
  endfunction

  logic [BW-1:0]      b;
  logic [PW-1:0]      p;
  logic               is_dig;
  logic [3:0]         dv;
  logic [PW-1:0]      acc_t;
  logic [PW-1:0]      acc_l;
  logic [PW-1:0]      acc_o;
  logic [PW-1:0]      acc_n;
  logic [4:0]         h;
  logic [BW-1:0]      chk;
  logic [9:1]         ef;
  efp_pkg::err_kind_t err_new;

  always_comb begin
    b      = item.data_byte;
    p      = pos_r;
    is_dig = (b >= efp_pkg::CH_0) && (b <= efp_pkg::CH_9);
    dv     = 4'(b - efp_pkg::CH_0);
    acc_t  = dec_shift(PW'(trn_r), dv);
    acc_l  = dec_shift(len_r, dv);
    acc_o  = dec_shift(PW'(op_r), dv);
    acc_n  = dec_shift(PW'(nack_r), dv);
    h      = hex_val(b);
    chk    = (p >= PW'(3)) ? BW'(sum_r - rb0_r - rb1_r) : '0;
    ef     = '0;

    pos_nxt   = pos_r;
    len_nxt   = len_r;
    trn_nxt   = trn_r;
    op_nxt    = op_r;
    reply_nxt = reply_r;
    ack_nxt   = ack_r;
    fc_nxt    = fc_r;
    fe_nxt    = fe_r;
    extra_nxt = extra_r;
    sum_nxt   = sum_r;
    rb0_nxt   = rb0_r;
    rb1_nxt   = rb1_r;
    hex_nxt   = hex_r;
    nack_nxt  = nack_r;
    ncnt_nxt  = ncnt_r;
    res       = '0;

    if (p == '0) begin
      ef[1] = (b != efp_pkg::CH_STX);
    end else if (p <= PW'(2)) begin
      if (is_dig) begin
        trn_nxt = acc_t[NW-1:0];
      end else begin
        ef[2] = 1'b1;
      end
    end else if (p == PW'(3) || p == PW'(9) || p == PW'(14)) begin
      ef[2] = is_dig;
    end else if (p <= PW'(8)) begin
      if (is_dig) begin
        len_nxt = acc_l;
      end else begin
        ef[2] = 1'b1;
      end
    end else if (p == PW'(10)) begin
      if (b == efp_pkg::CH_OP) begin
        reply_nxt = 1'b0;
      end else if (b == efp_pkg::CH_REPLY) begin
        reply_nxt = 1'b1;
      end else begin
        ef[4] = 1'b1;
      end
    end else if (p == PW'(12) || p == PW'(13)) begin
      if (is_dig) begin
        op_nxt = acc_o[NW-1:0];
      end else begin
        ef[2] = 1'b1;
      end
      if (p == PW'(13)) begin
        ef[5] = !type_known(op_nxt);
        if (!reply_r) begin
          fe_nxt = count_for_op(op_nxt);
        end
      end
    end else if (p == PW'(15) && reply_r) begin
      if (b == efp_pkg::CH_ACK) begin
        ack_nxt = 1'b1;
      end else if (b == efp_pkg::CH_NACK) begin
        ack_nxt = 1'b0;
      end else begin
        ef[6] = 1'b1;
      end
      fe_nxt = count_for_reply(op_r, ack_nxt);
    end

    if (!item.last_byte) begin
      if (p >= PW'(15)) begin
        if (b == efp_pkg::CH_SLASH) begin
          if (fc_r < fe_nxt) begin
            fc_nxt = fc_r + FW'(1);
          end else if (extra_r != '1) begin
            extra_nxt = extra_r + 8'd1;
          end
          hex_nxt = efp_pkg::HEX_EMPTY;
        end else begin
          if (fc_r < fe_nxt) begin
            res.field_byte       = b;
            res.field_index      = fc_r;
            res.field_byte_valid = 1'b1;
            if (fc_r == FW'(1) && reply_nxt && !ack_nxt) begin
              if (ncnt_r < 2'd2) begin
                if (is_dig) begin
                  nack_nxt = acc_n[NW-1:0];
                end else begin
                  ef[9] = 1'b1;
                end
              end else if (ncnt_r == 2'd2 && is_dig) begin
                ef[9] = 1'b1;
              end
              if (ncnt_r != 2'd3) begin
                ncnt_nxt = ncnt_r + 2'd1;
              end
            end
          end
          if (h[4]) begin
            hex_nxt = efp_pkg::HEX_BAD;
          end else if (hex_r == efp_pkg::HEX_EMPTY) begin
            hex_nxt = {5'b0, h[3:0]};
          end else if (!hex_r[8]) begin
            hex_nxt = (hex_r[7:4] != 4'd0) ? efp_pkg::HEX_BAD : {1'b0, hex_r[3:0], h[3:0]};
          end
        end
      end
      if (p != '0) begin
        sum_nxt = sum_r + b;
      end
      rb1_nxt = rb0_r;
      rb0_nxt = b;
      if (pos_r != '1) begin
        pos_nxt = pos_r + PW'(1);
      end
    end else begin
      ef[1] = ef[1] || (b != efp_pkg::CH_ETX);
      ef[2] = ef[2] || (p < PW'(14));
      ef[6] = ef[6] || (p < PW'(15) && reply_nxt);
      ef[3] = ({1'b0, p} + 18'd1) != ({1'b0, len_nxt} + 18'd2);
      ef[7] = fc_r < fe_nxt;
      ef[8] = hex_r[8] || (hex_r[7:0] != chk);
      ef[9] = reply_nxt && !ack_nxt && (ncnt_r < 2'd2);
    end

    err_new = min_err(err_r, ef);
    err_nxt = err_new;

    if (item.last_byte) begin
      res.frame_done         = 1'b1;
      res.frame_ok           = (err_new == efp_pkg::ERR_NONE);
      res.error_kind         = err_new;
      res.transaction_number = trn_nxt;
      res.operation_type     = op_nxt;
      res.is_reply           = reply_nxt;
      res.positive_ack       = reply_nxt && ack_nxt;
      res.nack_code          = (reply_nxt && !ack_nxt) ? nack_r : '0;
      res.extra_field_count  = extra_r;
      pos_nxt   = '0;
      len_nxt   = '0;
      trn_nxt   = '0;
      op_nxt    = '0;
      reply_nxt = 1'b0;
      ack_nxt   = 1'b0;
      fc_nxt    = '0;
      fe_nxt    = '0;
      extra_nxt = '0;
      sum_nxt   = '0;
      rb0_nxt   = '0;
      rb1_nxt   = '0;
      hex_nxt   = '0;
      nack_nxt  = '0;
      ncnt_nxt  = '0;
      err_nxt   = efp_pkg::ERR_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      len_r   <= '0;
      trn_r   <= '0;
      op_r    <= '0;
      reply_r <= 1'b0;
      ack_r   <= 1'b0;
      fc_r    <= '0;
      fe_r    <= '0;
      extra_r <= '0;
      sum_r   <= '0;
      rb0_r   <= '0;
      rb1_r   <= '0;
      hex_r   <= '0;
      nack_r  <= '0;
      ncnt_r  <= '0;
      err_r   <= efp_pkg::ERR_NONE;
    end else if (fire) begin
      pos_r   <= pos_nxt;
      len_r   <= len_nxt;
      trn_r   <= trn_nxt;
      op_r    <= op_nxt;
      reply_r <= reply_nxt;
      ack_r   <= ack_nxt;
      fc_r    <= fc_nxt;
      fe_r    <= fe_nxt;
      extra_r <= extra_nxt;
      sum_r   <= sum_nxt;
      rb0_r   <= rb0_nxt;
      rb1_r   <= rb1_nxt;
      hex_r   <= hex_nxt;
      nack_r  <= nack_nxt;
      ncnt_r  <= ncnt_nxt;
      err_r   <= err_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/efp_out_stage.sv
// ----------------------------------------------------------------------------
// EMI frame parser result register
// Holds one result until the receiving side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module efp_out_stage (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 src_valid,
  input  wire efp_pkg::efp_result_t src_res,
  output logic                      src_take,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output efp_pkg::efp_result_t      out_res
);

  logic                 valid_r;
  efp_pkg::efp_result_t res_r;

  assign src_take  = src_valid && (!valid_r || !out_stall);
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (src_take) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (src_take) begin
      res_r <= src_res;
    end
  end

endmodule

`default_nettype wire

>>> rtl/emi_frame_parser.sv
// Each byte is held in the input register, and its result in the result register.
// Throughput: one byte per cycle while the output is not stalled.
// A byte is taken while an earlier result waits, if the input register is empty or frees.
// Reset: synchronous, active low; clears the frame state and both stage valid flags.
// ----------------------------------------------------------------------------
// EMI frame parser
// Parses a UCP/EMI frame one byte per transfer, streams field bytes and reports status.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module emi_frame_parser #(
  parameter int unsigned OP01_FIELDS = efp_pkg::OP01_FIELDS_DEF,
  parameter int unsigned OP5X_FIELDS = efp_pkg::OP5X_FIELDS_DEF,
  parameter int unsigned OP60_FIELDS = efp_pkg::OP60_FIELDS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_last_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_field_byte,
  output logic [5:0]       out_field_index,
  output logic             out_field_byte_valid,
  output logic             out_frame_done,
  output logic             out_frame_ok,
  output logic [3:0]       out_error_kind,
  output logic [6:0]       out_transaction_number,
  output logic [6:0]       out_operation_type,
  output logic             out_is_reply,
  output logic             out_positive_ack,
  output logic [6:0]       out_nack_code,
  output logic [7:0]       out_extra_field_count
);

  efp_pkg::efp_item_t   in_item;
  efp_pkg::efp_item_t   item;
  logic                 item_valid;
  logic                 fire;
  efp_pkg::efp_result_t step_res;
  efp_pkg::efp_result_t res;

  assign in_item.data_byte = in_data_byte;
  assign in_item.last_byte = in_last_byte;

  efp_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .consume    (fire),
    .item_valid (item_valid),
    .item       (item)
  );

  efp_core #(
    .OP01_FIELDS (OP01_FIELDS),
    .OP5X_FIELDS (OP5X_FIELDS),
    .OP60_FIELDS (OP60_FIELDS)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (item),
    .res   (step_res)
  );

  efp_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .src_valid (item_valid),
    .src_res   (step_res),
    .src_take  (fire),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (res)
  );

  assign out_field_byte         = res.field_byte;
  assign out_field_index        = res.field_index;
  assign out_field_byte_valid   = res.field_byte_valid;
  assign out_frame_done         = res.frame_done;
  assign out_frame_ok           = res.frame_ok;
  assign out_error_kind         = res.error_kind;
  assign out_transaction_number = res.transaction_number;
  assign out_operation_type     = res.operation_type;
  assign out_is_reply           = res.is_reply;
  assign out_positive_ack       = res.positive_ack;
  assign out_nack_code          = res.nack_code;
  assign out_extra_field_count  = res.extra_field_count;

  `EFP_ASSERT_IMP(a_done_no_field, clk, rst_n, out_valid && out_frame_done, !out_field_byte_valid, "field byte flagged on frame end")
  `EFP_ASSERT_IMP(a_status_idle, clk, rst_n, out_valid && !out_frame_done, !out_frame_ok && out_error_kind == efp_pkg::ERR_NONE, "status set before frame end")
  `EFP_ASSERT_IMP(a_ok_matches, clk, rst_n, out_valid && out_frame_done, out_frame_ok == (out_error_kind == efp_pkg::ERR_NONE), "frame ok disagrees with error kind")
  `EFP_ASSERT_NXT(a_in_held, clk, rst_n, in_valid && !in_stall, item_valid, "accepted byte not held")

endmodule

`default_nettype wire

>>> tb/sv/emi_frame_parser_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// EMI frame parser testbench
// Builds UCP/EMI frames, some well formed and some damaged, and sends them
// byte by byte with random gaps and output stalls. Each byte accepted by the
// parser goes through a behavioural model of the parser. The result that the
// model predicts is queued, and each result transfer is checked field by field
// against the oldest prediction. A final frame carries enough surplus fields
// to saturate the extra field count.
// ----------------------------------------------------------------------------
module emi_frame_parser_tb;
  import efp_pkg::*;

  localparam int IDLE_LIMIT = 1000;
  localparam int RAND_BYTES = 500;
  localparam int SURPLUS_FIELDS = 262;
  localparam logic [POS_W-1:0] POS_TOP = '1;

  localparam int FR_OP   = 0;
  localparam int FR_ACK  = 1;
  localparam int FR_NACK = 2;

  logic       clk;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_data_byte = 8'h00;
  logic       in_last_byte = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_field_byte;
  logic [5:0] out_field_index;
  logic       out_field_byte_valid;
  logic       out_frame_done;
  logic       out_frame_ok;
  logic [3:0] out_error_kind;
  logic [6:0] out_transaction_number;
  logic [6:0] out_operation_type;
  logic       out_is_reply;
  logic       out_positive_ack;
  logic [6:0] out_nack_code;
  logic [7:0] out_extra_field_count;

  emi_frame_parser dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_data_byte           (in_data_byte),
    .in_last_byte           (in_last_byte),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_field_byte         (out_field_byte),
    .out_field_index        (out_field_index),
    .out_field_byte_valid   (out_field_byte_valid),
    .out_frame_done         (out_frame_done),
    .out_frame_ok           (out_frame_ok),
    .out_error_kind         (out_error_kind),
    .out_transaction_number (out_transaction_number),
    .out_operation_type     (out_operation_type),
    .out_is_reply           (out_is_reply),
    .out_positive_ack       (out_positive_ack),
    .out_nack_code          (out_nack_code),
    .out_extra_field_count  (out_extra_field_count)
  );

  // Parser state as the model keeps it.
  logic [POS_W-1:0]      at_pos;
  logic [POS_W-1:0]      decl_len;
  logic [NUM_W-1:0]      trn_val;
  logic [NUM_W-1:0]      op_val;
  logic                  reply_seen;
  logic                  ack_seen;
  logic [FIELD_W-1:0]    fld_cnt;
  logic [FIELD_W-1:0]    fld_need;
  logic [EXTRA_W-1:0]    extra_cnt;
  logic [7:0]            byte_sum;
  logic [7:0]            last_b0;
  logic [7:0]            last_b1;
  logic [HEX_W-1:0]      hex_acc;
  logic [NUM_W-1:0]      nack_val;
  logic [NACK_CNT_W-1:0] nack_cnt;
  err_kind_t             first_fault;

  efp_item_t   pend_q[$];
  efp_result_t expect_q[$];
  logic [7:0]  frame_buf[$];

  logic in_took = 1'b0;
  bit   hush = 1'b0;
  int   send_wait = 0;
  int   stall_left = 0;
  int   calm_left = 0;
  int   idle_run = 0;
  int   mismatches = 0;
  int   results_seen = 0;
  int   frames_queued = 0;
  int   bytes_queued = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic bit is_num(logic [7:0] b);
    return b >= CH_0 && b <= CH_9;
  endfunction

  task automatic note_fault(err_kind_t k);
    if (first_fault == ERR_NONE || k < first_fault) first_fault = k;
  endtask

  task automatic clear_frame();
    at_pos = '0;
    decl_len = '0;
    trn_val = '0;
    op_val = '0;
    reply_seen = 1'b0;
    ack_seen = 1'b0;
    fld_cnt = '0;
    fld_need = '0;
    extra_cnt = '0;
    byte_sum = '0;
    last_b0 = '0;
    last_b1 = '0;
    hex_acc = '0;
    nack_val = '0;
    nack_cnt = '0;
    first_fault = ERR_NONE;
  endtask

  // Advances the model by one byte and gives the result that byte produces.
  task automatic parse_byte(input logic [7:0] b, input logic fin, output efp_result_t r);
    logic [POS_W-1:0] p;
    logic [7:0] chk;
    int h;
    int v;
    p = at_pos;
    r = '0;
    if (p == 0) begin
      if (b != CH_STX) note_fault(ERR_MARKER);
    end else if (p <= 2) begin
      if (is_num(b)) trn_val = NUM_W'(trn_val * 10 + (b - CH_0));
      else note_fault(ERR_DIGIT);
    end else if (p == 3 || p == 9 || p == 14) begin
      if (is_num(b)) note_fault(ERR_DIGIT);
    end else if (p <= 8) begin
      if (is_num(b)) decl_len = POS_W'(decl_len * 10 + (b - CH_0));
      else note_fault(ERR_DIGIT);
    end else if (p == 10) begin
      if (b == CH_OP) reply_seen = 1'b0;
      else if (b == CH_REPLY) reply_seen = 1'b1;
      else note_fault(ERR_DIR);
    end else if (p == 12 || p == 13) begin
      if (is_num(b)) op_val = NUM_W'(op_val * 10 + (b - CH_0));
      else note_fault(ERR_DIGIT);
      if (p == 13) begin
        if (!(op_val == OP_01 || op_val == OP_31 || (op_val >= OP_51 && op_val <= OP_53) ||
              op_val == OP_60)) note_fault(ERR_TYPE);
        if (!reply_seen) begin
          if (op_val == OP_01) fld_need = FIELD_W'(OP01_FIELDS_DEF);
          else if (op_val == OP_31) fld_need = FIELD_W'(2);
          else if (op_val >= OP_51 && op_val <= OP_53) fld_need = FIELD_W'(OP5X_FIELDS_DEF);
          else if (op_val == OP_60) fld_need = FIELD_W'(OP60_FIELDS_DEF);
          else fld_need = '0;
        end
      end
    end else if (p == 15 && reply_seen) begin
      if (b == CH_ACK) ack_seen = 1'b1;
      else if (b == CH_NACK) ack_seen = 1'b0;
      else note_fault(ERR_ACK);
      if (op_val == OP_01 || op_val == OP_31 || op_val == OP_60)
        fld_need = ack_seen ? FIELD_W'(2) : FIELD_W'(3);
      else if (op_val >= OP_51 && op_val <= OP_53) fld_need = FIELD_W'(3);
      else fld_need = '0;
    end

    if (!fin) begin
      if (p >= 15) begin
        if (b == CH_SLASH) begin
          if (fld_cnt < fld_need) fld_cnt = fld_cnt + FIELD_W'(1);
          else if (extra_cnt != 8'hFF) extra_cnt = extra_cnt + 8'd1;
          hex_acc = HEX_EMPTY;
        end else begin
          if (b >= CH_0 && b <= CH_9) h = int'(b - CH_0);
          else if (b >= CH_UA && b <= CH_UF) h = int'(b - CH_UA) + 10;
          else if (b >= CH_LA && b <= CH_LF) h = int'(b - CH_LA) + 10;
          else h = -1;
          if (fld_cnt < fld_need) begin
            r.field_byte = b;
            r.field_index = fld_cnt;
            r.field_byte_valid = 1'b1;
            if (fld_cnt == 1 && reply_seen && !ack_seen) begin
              if (nack_cnt < 2) begin
                if (is_num(b)) nack_val = NUM_W'(nack_val * 10 + (b - CH_0));
                else note_fault(ERR_NACK);
              end else if (nack_cnt == 2 && is_num(b)) begin
                note_fault(ERR_NACK);
              end
              if (nack_cnt < 3) nack_cnt = nack_cnt + 2'd1;
            end
          end
          if (h < 0) begin
            hex_acc = HEX_BAD;
          end else if (hex_acc == HEX_EMPTY) begin
            hex_acc = HEX_W'(h);
          end else if (hex_acc <= 9'h0FF) begin
            v = hex_acc * 16 + h;
            hex_acc = (v > 255) ? HEX_BAD : HEX_W'(v);
          end
        end
      end
      if (p >= 1) byte_sum = byte_sum + b;
      last_b1 = last_b0;
      last_b0 = b;
      if (at_pos != POS_TOP) at_pos = at_pos + POS_W'(1);
    end else begin
      if (b != CH_ETX) note_fault(ERR_MARKER);
      if (p < 14) note_fault(ERR_DIGIT);
      if (p < 15 && reply_seen) note_fault(ERR_ACK);
      if (p + 1 != decl_len + 2) note_fault(ERR_LENGTH);
      if (fld_cnt < fld_need) note_fault(ERR_FIELDS);
      chk = (p >= 3) ? byte_sum - last_b0 - last_b1 : 8'h00;
      if (hex_acc > 9'h0FF || hex_acc != {1'b0, chk}) note_fault(ERR_CHECKSUM);
      if (reply_seen && !ack_seen && nack_cnt < 2) note_fault(ERR_NACK);
      r.frame_done = 1'b1;
      r.frame_ok = (first_fault == ERR_NONE);
      r.error_kind = first_fault;
      r.transaction_number = trn_val;
      r.operation_type = op_val;
      r.is_reply = reply_seen;
      r.positive_ack = reply_seen && ack_seen;
      r.nack_code = (reply_seen && !ack_seen) ? nack_val : '0;
      r.extra_field_count = extra_cnt;
      clear_frame();
    end
  endtask

  task automatic report_mismatch(string msg);
    mismatches++;
    $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  task automatic compare_field(string name, int got, int exp_v);
    if (got != exp_v)
      report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                results_seen, name, got, exp_v));
  endtask

  function automatic int pick_gap();
    int r;
    if (hush) return 0;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      calm_left = $urandom_range(30, 150);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] field_char();
    logic [7:0] b;
    do
      b = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) :
                                        8'($urandom_range(8'h30, 8'h7A));
    while (b == CH_SLASH);
    return b;
  endfunction

  task automatic put_text(string s);
    for (int i = 0; i < s.len(); i++) frame_buf.push_back(s[i]);
  endtask

  task automatic add_fields(int n);
    repeat (n) begin
      repeat ($urandom_range(0, 4)) frame_buf.push_back(field_char());
      frame_buf.push_back(CH_SLASH);
    end
  endtask

  task automatic begin_frame(int trn, logic [7:0] dir, int op);
    frame_buf = {};
    frame_buf.push_back(CH_STX);
    put_text($sformatf("%02d/00000/%c/%02d/", trn, dir, op));
  endtask

  // Fills in the length, then appends the checksum and the end marker.
  task automatic end_frame();
    string txt;
    logic [7:0] chk;
    txt = $sformatf("%05d", frame_buf.size() + 1);
    for (int i = 0; i < 5; i++) frame_buf[4 + i] = txt[i];
    chk = '0;
    for (int i = 1; i < frame_buf.size(); i++) chk += frame_buf[i];
    txt = ($urandom_range(0, 3) == 0) ? $sformatf("%02x", chk) : $sformatf("%02X", chk);
    put_text(txt);
    frame_buf.push_back(CH_ETX);
  endtask

  // Builds a frame with the field count the operation calls for, plus delta.
  task automatic build_frame(int trn, int op, int mode, int delta, string nack_txt);
    int total;
    total = 0;
    if (mode == FR_OP) begin
      if (op == OP_01) total = OP01_FIELDS_DEF;
      else if (op == OP_31) total = 2;
      else if (op >= OP_51 && op <= OP_53) total = OP5X_FIELDS_DEF;
      else if (op == OP_60) total = OP60_FIELDS_DEF;
    end else if (op == OP_01 || op == OP_31 || op == OP_60) begin
      total = (mode == FR_ACK) ? 2 : 3;
    end else if (op >= OP_51 && op <= OP_53) begin
      total = 3;
    end
    begin_frame(trn, (mode == FR_OP) ? CH_OP : CH_REPLY, op);
    if (mode == FR_ACK) begin
      put_text("A/");
      total -= 1;
    end else if (mode == FR_NACK) begin
      put_text({"N/", nack_txt, "/"});
      total -= 2;
    end
    add_fields(total + delta);
    end_frame();
  endtask

  task automatic send_frame();
    efp_item_t it;
    foreach (frame_buf[i]) begin
      it.data_byte = frame_buf[i];
      it.last_byte = (i == frame_buf.size() - 1);
      pend_q.push_back(it);
    end
    frames_queued++;
    bytes_queued += frame_buf.size();
  endtask

  task automatic settle();
    while (pend_q.size() != 0 || in_valid || expect_q.size() != 0) @(negedge clk);
  endtask

  always @(negedge clk) begin : send_side
    efp_item_t nxt;
    if (rst_n && (!in_valid || in_took)) begin
      if (send_wait > 0) begin
        send_wait--;
        in_valid <= 1'b0;
      end else if (pend_q.size() > 0) begin
        nxt = pend_q.pop_front();
        in_data_byte <= nxt.data_byte;
        in_last_byte <= nxt.last_byte;
        in_valid <= 1'b1;
        send_wait = pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin : stall_side
    if (rst_n) begin
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin : watch_side
    efp_result_t want;
    if (!rst_n) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_valid && !in_stall;
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expect_q.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with no byte outstanding",
                                    results_seen));
        end else begin
          want = expect_q.pop_front();
          compare_field("field_byte", out_field_byte, want.field_byte);
          compare_field("field_index", out_field_index, want.field_index);
          compare_field("field_byte_valid", out_field_byte_valid, want.field_byte_valid);
          compare_field("frame_done", out_frame_done, want.frame_done);
          compare_field("frame_ok", out_frame_ok, want.frame_ok);
          compare_field("error_kind", out_error_kind, want.error_kind);
          compare_field("transaction_number", out_transaction_number,
                        want.transaction_number);
          compare_field("operation_type", out_operation_type, want.operation_type);
          compare_field("is_reply", out_is_reply, want.is_reply);
          compare_field("positive_ack", out_positive_ack, want.positive_ack);
          compare_field("nack_code", out_nack_code, want.nack_code);
          compare_field("extra_field_count", out_extra_field_count, want.extra_field_count);
        end
      end
      if (in_valid && !in_stall) begin
        parse_byte(in_data_byte, in_last_byte, want);
        expect_q.push_back(want);
      end
    end
  end

  always @(posedge clk) begin : idle_watch
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_run <= 0;
      end else if (idle_run >= IDLE_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end else begin
        idle_run <= idle_run + 1;
      end
    end
  end

  initial begin : stimulus
    int known_ops[6];
    int r;
    int op;
    int mode;
    int k;
    int start_bytes;
    string nack_txt;
    known_ops = '{1, 31, 51, 52, 53, 60};
    clear_frame();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Well formed frames of every operation and direction.
    build_frame(0, 1, FR_OP, 0, ""); send_frame();
    build_frame(99, 31, FR_OP, 0, ""); send_frame();
    build_frame(12, 51, FR_OP, 0, ""); send_frame();
    build_frame(13, 52, FR_OP, 0, ""); send_frame();
    build_frame(14, 53, FR_OP, 0, ""); send_frame();
    build_frame(15, 60, FR_OP, 0, ""); send_frame();
    build_frame(16, 1, FR_ACK, 0, ""); send_frame();
    build_frame(17, 31, FR_NACK, 0, "02"); send_frame();
    build_frame(18, 52, FR_NACK, 0, "99"); send_frame();
    build_frame(19, 60, FR_ACK, 0, ""); send_frame();
    build_frame(20, 53, FR_ACK, 0, ""); send_frame();
    build_frame(21, 1, FR_OP, 3, ""); send_frame();
    // Damaged frames, covering each fault kind.
    build_frame(22, 1, FR_OP, -1, ""); send_frame();
    build_frame(23, 1, FR_OP, 0, ""); frame_buf[0] = 8'h01; send_frame();
    build_frame(24, 1, FR_OP, 0, ""); frame_buf[frame_buf.size() - 1] = 8'h04; send_frame();
    build_frame(25, 1, FR_OP, 0, ""); frame_buf[2] = "x"; send_frame();
    build_frame(26, 1, FR_OP, 0, ""); frame_buf[3] = "7"; send_frame();
    build_frame(27, 1, FR_OP, 0, ""); frame_buf[4] = "9"; send_frame();
    build_frame(28, 1, FR_OP, 0, ""); frame_buf[10] = "X"; send_frame();
    build_frame(29, 99, FR_OP, 0, ""); send_frame();
    build_frame(30, 1, FR_ACK, 0, ""); frame_buf[15] = "Q"; send_frame();
    build_frame(31, 1, FR_ACK, 0, "");
    frame_buf = frame_buf[0:13]; frame_buf.push_back(CH_ETX); send_frame();
    build_frame(32, 1, FR_OP, 0, "");
    frame_buf = frame_buf[0:4]; frame_buf.push_back(CH_ETX); send_frame();
    frame_buf = {}; frame_buf.push_back(CH_ETX); send_frame();
    build_frame(33, 60, FR_OP, 0, ""); frame_buf[frame_buf.size() - 2] = "G"; send_frame();
    build_frame(34, 31, FR_OP, 0, "");
    frame_buf[frame_buf.size() - 2] = (frame_buf[frame_buf.size() - 2] == "0") ? "1" : "0";
    send_frame();
    build_frame(35, 31, FR_OP, 0, ""); frame_buf.insert(frame_buf.size() - 3, "0"); send_frame();
    build_frame(36, 31, FR_OP, 0, "");
    frame_buf.delete(frame_buf.size() - 2); frame_buf.delete(frame_buf.size() - 2); send_frame();
    build_frame(37, 31, FR_NACK, 0, "7"); send_frame();
    build_frame(38, 1, FR_NACK, 0, "123"); send_frame();
    build_frame(39, 60, FR_NACK, 0, "x5"); send_frame();
    build_frame(40, 51, FR_NACK, 0, ""); send_frame();
    settle();

    // Random frames: mostly well formed, the rest damaged, cut short or noise.
    start_bytes = bytes_queued;
    while (bytes_queued - start_bytes < RAND_BYTES) begin
      op = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : known_ops[$urandom_range(0, 5)];
      mode = $urandom_range(FR_OP, FR_NACK);
      case ($urandom_range(0, 9))
        0: nack_txt = $sformatf("%0d", $urandom_range(0, 9));
        1: nack_txt = $sformatf("%03d", $urandom_range(0, 999));
        2: nack_txt = $sformatf("%c%0d", $urandom_range(8'h41, 8'h5A), $urandom_range(0, 9));
        default: nack_txt = $sformatf("%02d", $urandom_range(0, 99));
      endcase
      build_frame($urandom_range(0, 99), op, mode,
                  ($urandom_range(0, 4) == 0) ? $urandom_range(0, 4) - 1 : 0, nack_txt);
      r = $urandom_range(0, 99);
      if (r >= 93) begin
        frame_buf = {};
        repeat ($urandom_range(1, 40)) frame_buf.push_back(8'($urandom_range(0, 255)));
      end else if (r >= 85) begin
        k = $urandom_range(1, frame_buf.size() - 1);
        frame_buf = frame_buf[0:k - 1];
        frame_buf.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : CH_ETX);
      end else if (r >= 70) begin
        frame_buf[$urandom_range(0, frame_buf.size() - 1)] = 8'($urandom_range(0, 255));
      end
      send_frame();
      if ($urandom_range(0, 19) == 0) settle();
    end
    settle();

    // One frame with more surplus fields than the extra count holds, sent without gaps.
    hush = 1'b1;
    begin_frame(1, CH_OP, 31);
    repeat (SURPLUS_FIELDS) frame_buf.push_back(CH_SLASH);
    end_frame();
    send_frame();
    settle();
    hush = 1'b0;

    repeat (10) @(negedge clk);
    $display("Checked %0d results from %0d frames (%0d bytes): every operation, both",
             results_seen, frames_queued, bytes_queued);
    $display("directions, each fault kind, random frames and a saturated extra field count.");
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
